FILE: hw/rtl/lphs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_pkg
// shared widths, operation codes and controller/datapath interface types for
// the linear probing hash set
// ----------------------------------------------------------------------------
package lphs_pkg;

  localparam int KEY_W         = 31;
  localparam int CFG_W         = 11;
  localparam int FUNC_W        = 2;
  localparam int DEFAULT_DEPTH = 1024;
  localparam int DIV_CNT_W     = $clog2(KEY_W);

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1024);

  // operation codes carried in s_tuser
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEST   = 2'd2;

  // how an item ended, decides the result fields
  typedef enum logic [2:0] {
    RES_HIT,
    RES_EMPTY,
    RES_FULL,
    RES_ZERO,
    RES_NOP,
    RES_CLEAR
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      probe_init;
    logic      probe_adv;
    logic      write_key;
    logic      clr_step;
    logic      out_load;
    res_kind_t kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              key_zero;
    logic              div_last;
    logic              hit;
    logic              empty;
    logic              probe_last;
    logic              clr_last;
  } dp_status_t;

endpackage

FILE: hw/rtl/linear_probe_hash_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// hash set of positive keys, open addressing with linear probing
// ----------------------------------------------------------------------------
// One item is in work at a time; the next one is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// For an insert or test the home slot comes from a bit-serial remainder, one
// key bit per cycle over all 31 key bits, and the probe then visits from one
// slot up to the table size; each probed slot costs a read and a compare on
// the single read port of the key memory. A zero key or an unused operation
// code skips the remainder and the probe. A clear sweeps every slot of the
// memory, one per cycle. After reset the same sweep runs with s_tready low;
// configuration writes are taken at any time.
// The table size register sets the hash modulus; 0 acts as 1 and values
// above TABLE_DEPTH act as TABLE_DEPTH. An insert into a full table is
// dropped and reported with table_full set.
// ----------------------------------------------------------------------------
module linear_probe_hash_set #(
  parameter int  TABLE_DEPTH = lphs_pkg::DEFAULT_DEPTH,
  localparam int SLOT_W      = $clog2(TABLE_DEPTH),
  localparam int OUT_W       = ((SLOT_W + 3 + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,   // key[30:0], zero pad
  input  logic [lphs_pkg::FUNC_W-1:0] s_tuser,   // func[1:0]
  // results
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [OUT_W-1:0]            m_tdata,   // found, slot, table_full, all_found, zero pad
  // table size register
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lphs_pkg::CFG_W-1:0]  cfg_data
);

  lphs_pkg::ctl_cmd_t   cmd;
  lphs_pkg::dp_status_t status;

  // register write is always accepted
  assign cfg_ready = 1'b1;

  // sequencer: clear sweep, remainder steps, probe walk, result hand-off
  lphs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // key memory, remainder unit, probe pointer and result register
  lphs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_key   (s_tdata[lphs_pkg::KEY_W-1:0]),
    .in_func  (s_tuser),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .out_data (m_tdata)
  );

endmodule

FILE: hw/rtl/lphs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_datapath
// key table memory, bit-serial remainder, probe pointer, clear sweep and
// result register
// ----------------------------------------------------------------------------
module lphs_datapath #(
  parameter int  TABLE_DEPTH = lphs_pkg::DEFAULT_DEPTH,
  localparam int SLOT_W      = $clog2(TABLE_DEPTH),
  localparam int N_W         = $clog2(TABLE_DEPTH + 1),
  localparam int OUT_W       = ((SLOT_W + 3 + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lphs_pkg::ctl_cmd_t           cmd,
  output lphs_pkg::dp_status_t         status,
  input  logic [lphs_pkg::KEY_W-1:0]   in_key,
  input  logic [lphs_pkg::FUNC_W-1:0]  in_func,
  input  logic                         cfg_we,
  input  logic [lphs_pkg::CFG_W-1:0]   cfg_data,
  output logic [OUT_W-1:0]             out_data
);

  logic [lphs_pkg::KEY_W-1:0]     slot_keys [TABLE_DEPTH];
  logic [lphs_pkg::KEY_W-1:0]     rd_data;
  logic [lphs_pkg::KEY_W-1:0]     key_q;
  logic [lphs_pkg::FUNC_W-1:0]    func_q;
  logic [lphs_pkg::CFG_W-1:0]     table_size;
  logic [N_W-1:0]                 size_eff;
  logic [N_W-1:0]                 n_q;
  logic [lphs_pkg::KEY_W-1:0]     div_sh;
  logic [lphs_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [N_W-1:0]                 rem;
  logic [N_W:0]                   rem_shift;
  logic [N_W:0]                   rem_diff;
  logic [SLOT_W-1:0]              pos;
  logic [N_W-1:0]                 pos_inc;
  logic [N_W-1:0]                 cnt;
  logic [SLOT_W-1:0]              clr_addr;
  logic                           all_flag;
  logic                           flag_next;
  logic                           res_found;
  logic [SLOT_W-1:0]              res_slot;
  logic                           res_full;
  logic                           out_found;
  logic [SLOT_W-1:0]              out_slot;
  logic                           out_full;
  logic                           out_all;
  logic                           mem_we;
  logic [SLOT_W-1:0]              mem_waddr;
  logic [lphs_pkg::KEY_W-1:0]     mem_wdata;
  logic                           is_test;
  logic                           is_insert;

  // size in use: zero acts as one, clamp at the memory depth
  always_comb begin
    if (table_size == '0) begin
      size_eff = N_W'(1);
    end else if (int'(table_size) > TABLE_DEPTH) begin
      size_eff = N_W'(TABLE_DEPTH);
    end else begin
      size_eff = N_W'(table_size);
    end
  end

  // restoring remainder, one key bit per step
  assign rem_shift = {rem, div_sh[lphs_pkg::KEY_W-1]};
  assign rem_diff  = rem_shift - {1'b0, n_q};

  assign pos_inc = N_W'(pos) + N_W'(1);

  assign is_test   = (func_q == lphs_pkg::FUNC_TEST);
  assign is_insert = (func_q == lphs_pkg::FUNC_INSERT);

  assign mem_we    = cmd.clr_step | cmd.write_key;
  assign mem_waddr = cmd.clr_step ? clr_addr : pos;
  assign mem_wdata = cmd.clr_step ? '0 : key_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_keys[mem_waddr] <= mem_wdata;
    end
    rd_data <= slot_keys[pos];
  end

  assign status.func       = func_q;
  assign status.key_zero   = (key_q == '0);
  assign status.div_last   = (div_cnt == lphs_pkg::DIV_CNT_W'(lphs_pkg::KEY_W - 1));
  assign status.hit        = (rd_data == key_q);
  assign status.empty      = (rd_data == '0);
  assign status.probe_last = (cnt == n_q - N_W'(1));
  assign status.clr_last   = (clr_addr == SLOT_W'(TABLE_DEPTH - 1));

  always_comb begin
    res_found = 1'b0;
    res_slot  = '0;
    res_full  = 1'b0;
    flag_next = all_flag;
    case (cmd.kind)
      lphs_pkg::RES_HIT: begin
        res_found = 1'b1;
        res_slot  = pos;
      end
      lphs_pkg::RES_EMPTY: begin
        res_found = is_insert;
        res_slot  = pos;
        if (is_test) flag_next = 1'b0;
      end
      lphs_pkg::RES_FULL: begin
        res_slot  = rem[SLOT_W-1:0];
        res_full  = 1'b1;
        if (is_test) flag_next = 1'b0;
      end
      lphs_pkg::RES_ZERO: begin
        if (is_test) flag_next = 1'b0;
      end
      lphs_pkg::RES_CLEAR: begin
        flag_next = 1'b1;
      end
      default: begin
        flag_next = all_flag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= lphs_pkg::SIZE_RESET;
      all_flag   <= 1'b1;
      clr_addr   <= '0;
    end else begin
      if (cfg_we) table_size <= cfg_data;
      if (cmd.out_load) all_flag <= flag_next;
      if (cmd.load) begin
        clr_addr <= '0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q   <= in_key;
      func_q  <= in_func;
      n_q     <= size_eff;
      div_sh  <= in_key;
      div_cnt <= '0;
      rem     <= '0;
    end else if (cmd.div_step) begin
      div_sh  <= div_sh << 1;
      div_cnt <= div_cnt + lphs_pkg::DIV_CNT_W'(1);
      if (rem_shift >= {1'b0, n_q}) begin
        rem <= rem_diff[N_W-1:0];
      end else begin
        rem <= rem_shift[N_W-1:0];
      end
    end
    if (cmd.probe_init) begin
      pos <= rem[SLOT_W-1:0];
      cnt <= '0;
    end else if (cmd.probe_adv) begin
      pos <= (pos_inc == n_q) ? '0 : pos_inc[SLOT_W-1:0];
      cnt <= cnt + N_W'(1);
    end
    if (cmd.out_load) begin
      out_found <= res_found;
      out_slot  <= res_slot;
      out_full  <= res_full;
      out_all   <= flag_next;
    end
  end

  assign out_data = OUT_W'({out_all, out_full, out_slot, out_found});

`ifndef ASSERT_OFF
  a_write_into_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.write_key |-> (rd_data == '0))
    else $error("key written over an occupied slot");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.probe_adv || cmd.write_key) |-> (N_W'(pos) < n_q))
    else $error("probe pointer outside the table in use");
`endif

endmodule

FILE: hw/rtl/lphs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_ctrl
// sequencer for clear sweep, remainder, probe walk and result hand-off
// ----------------------------------------------------------------------------
module lphs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  lphs_pkg::dp_status_t status,
  output lphs_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_DISP,
    S_CLR,
    S_DIV,
    S_HOME,
    S_RD,
    S_CMP,
    S_FIN
  } state_t;

  state_t               state;
  state_t               state_next;
  lphs_pkg::res_kind_t  kind;
  lphs_pkg::res_kind_t  kind_next;
  logic                 out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    kind_next  = kind;
    case (state)
      S_INIT_CLR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (status.func == lphs_pkg::FUNC_CLEAR) begin
          state_next = S_CLR;
        end else if (status.func == lphs_pkg::FUNC_INSERT ||
                     status.func == lphs_pkg::FUNC_TEST) begin
          if (status.key_zero) begin
            kind_next  = lphs_pkg::RES_ZERO;
            state_next = S_FIN;
          end else begin
            state_next = S_DIV;
          end
        end else begin
          kind_next  = lphs_pkg::RES_NOP;
          state_next = S_FIN;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          kind_next  = lphs_pkg::RES_CLEAR;
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_HOME;
      end
      S_HOME: begin
        cmd.probe_init = 1'b1;
        state_next     = S_RD;
      end
      S_RD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (status.hit) begin
          kind_next  = lphs_pkg::RES_HIT;
          state_next = S_FIN;
        end else if (status.empty) begin
          cmd.write_key = (status.func == lphs_pkg::FUNC_INSERT);
          kind_next     = lphs_pkg::RES_EMPTY;
          state_next    = S_FIN;
        end else if (status.probe_last) begin
          kind_next  = lphs_pkg::RES_FULL;
          state_next = S_FIN;
        end else begin
          cmd.probe_adv = 1'b1;
          state_next    = S_RD;
        end
      end
      S_FIN: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.kind = kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT_CLR;
      kind      <= lphs_pkg::RES_NOP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is in work");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FIN))
    else $error("result presented without a finished item");

  a_hit_ends_probe: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && status.hit) |=> (state == S_FIN && kind == lphs_pkg::RES_HIT))
    else $error("probe did not stop on a matching key");
`endif

endmodule
